@@ rtl/mqtt_packet_deframer_unit_macros.svh @@
// Assertion macros for the deframer checkers.
`ifndef MQTT_PACKET_DEFRAMER_UNIT_MACROS_SVH
`define MQTT_PACKET_DEFRAMER_UNIT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define MPD_ASSERT_IMP(lbl, clock, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clock) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, held off during reset.
`define MPD_ASSERT_NXT(lbl, clock, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clock) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/mpd_pkg.sv @@
`default_nettype none

package mpd_pkg;

	typedef enum logic [3:0] {
		PH_HDR    = 4'd0,
		PH_LEN    = 4'd1,
		PH_PNL_HI = 4'd2,
		PH_PNL_LO = 4'd3,
		PH_PNAME  = 4'd4,
		PH_SKIP4  = 4'd5,
		PH_IDL_HI = 4'd6,
		PH_IDL_LO = 4'd7,
		PH_CID    = 4'd8,
		PH_IGNORE = 4'd9,
		PH_TL_HI  = 4'd10,
		PH_TL_LO  = 4'd11,
		PH_TOPIC  = 4'd12,
		PH_AFTER  = 4'd13,
		PH_PID_HI = 4'd14,
		PH_PID_LO = 4'd15
	} phase_t;

	localparam logic [3:0] ROLE_HEADER    = 4'd0;
	localparam logic [3:0] ROLE_LENGTH    = 4'd1;
	localparam logic [3:0] ROLE_SKIPPED   = 4'd2;
	localparam logic [3:0] ROLE_TOPIC_LEN = 4'd3;
	localparam logic [3:0] ROLE_TOPIC     = 4'd4;
	localparam logic [3:0] ROLE_PACKET_ID = 4'd5;
	localparam logic [3:0] ROLE_QOS       = 4'd6;
	localparam logic [3:0] ROLE_PAYLOAD   = 4'd7;
	localparam logic [3:0] ROLE_ID_LEN    = 4'd8;
	localparam logic [3:0] ROLE_CLIENT_ID = 4'd9;
	localparam logic [3:0] ROLE_IGNORED   = 4'd10;

	localparam logic [3:0] KIND_CONNECT   = 4'd1;
	localparam logic [3:0] KIND_PUBLISH   = 4'd3;
	localparam logic [3:0] KIND_SUBSCRIBE = 4'd8;
	localparam logic [3:0] KIND_PINGREQ   = 4'd12;

	localparam logic [1:0] REPLY_NONE     = 2'd0;
	localparam logic [1:0] REPLY_CONNACK  = 2'd1;
	localparam logic [1:0] REPLY_SUBACK   = 2'd2;
	localparam logic [1:0] REPLY_PINGRESP = 2'd3;

	localparam logic [2:0]  LEN_MAX_BYTES = 3'd4;
	localparam logic [7:0]  TOPIC_MAX     = 8'd255;
	localparam logic [15:0] SKIP4_COUNT   = 16'd4;

	typedef struct packed {
		logic [3:0]  packet_kind;
		logic [3:0]  byte_role;
		logic [7:0]  echo_byte;
		logic [15:0] field_value;
		logic        field_done;
		logic        packet_end;
		logic [1:0]  reply_due;
		logic [7:0]  topic_total;
		logic        malformed;
	} result_t;

	function automatic logic [1:0] reply_for(input logic [3:0] kind);
		logic [1:0] r;
		case (kind)
			KIND_CONNECT:   r = REPLY_CONNACK;
			KIND_SUBSCRIBE: r = REPLY_SUBACK;
			KIND_PINGREQ:   r = REPLY_PINGRESP;
			default:        r = REPLY_NONE;
		endcase
		return r;
	endfunction

	function automatic phase_t body_start(input logic [3:0] kind);
		phase_t p;
		case (kind)
			KIND_CONNECT:   p = PH_PNL_HI;
			KIND_PUBLISH:   p = PH_TL_HI;
			KIND_SUBSCRIBE: p = PH_PID_HI;
			default:        p = PH_IGNORE;
		endcase
		return p;
	endfunction

endpackage

`default_nettype wire

@@ rtl/mqtt_packet_deframer_unit.sv @@
`default_nettype none
// Channel   Handshake                  Payload
// input     byte_valid / byte_stall    data_byte
// result    result_valid / result_stall packet_kind, byte_role, echo_byte, field_value,
//                                      field_done, packet_end, reply_due, topic_total,
//                                      malformed
// One result per byte, held in the result register; a byte every cycle unless stalled.
// The phase and length counters update in the same cycle as the byte transfer.
// Reset clears the parser to awaiting a fixed header and empties the result register.
// A stalled result holds; a new byte is taken whenever the result register is empty
// or being drained in the same cycle.

module mqtt_packet_deframer_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        byte_valid,
	output logic             byte_stall,
	input  wire logic [7:0]  data_byte,
	output logic             result_valid,
	input  wire logic        result_stall,
	output logic [3:0]       packet_kind,
	output logic [3:0]       byte_role,
	output logic [7:0]       echo_byte,
	output logic [15:0]      field_value,
	output logic             field_done,
	output logic             packet_end,
	output logic [1:0]       reply_due,
	output logic [7:0]       topic_total,
	output logic             malformed
);
	import mpd_pkg::*;

	phase_t      phase_q, phase_d;
	logic [3:0]  kind_q, kind_d;
	logic [27:0] left_q, left_d;
	logic [2:0]  lcnt_q, lcnt_d;
	logic [15:0] accum_q, accum_d;
	logic [15:0] str_q, str_d;
	logic [7:0]  topics_q, topics_d;

	result_t     res_d, res_q;
	logic        result_valid_q;
	logic        accept;

	logic [27:0] len_frag, len_or, left_dec;
	logic [15:0] str_dec, fv;
	logic        str_done;

	assign byte_stall = result_valid_q && result_stall;
	assign accept     = byte_valid && !byte_stall;

	always_comb begin
		case (lcnt_q[1:0])
			2'd0:    len_frag = {21'd0, data_byte[6:0]};
			2'd1:    len_frag = {14'd0, data_byte[6:0], 7'd0};
			2'd2:    len_frag = {7'd0, data_byte[6:0], 14'd0};
			default: len_frag = {data_byte[6:0], 21'd0};
		endcase
	end

	assign len_or   = left_q | len_frag;
	assign left_dec = (left_q != 28'd0) ? left_q - 28'd1 : left_q;
	assign str_dec  = (str_q != 16'd0) ? str_q - 16'd1 : str_q;
	assign str_done = (str_dec == 16'd0);
	assign fv       = accum_q | {8'd0, data_byte};

	always_comb begin
		phase_d  = phase_q;
		kind_d   = kind_q;
		left_d   = left_q;
		lcnt_d   = lcnt_q;
		accum_d  = accum_q;
		str_d    = str_q;
		topics_d = topics_q;

		res_d             = '0;
		res_d.byte_role   = ROLE_IGNORED;
		res_d.echo_byte   = data_byte;

		unique case (phase_q)
			PH_HDR: begin
				kind_d          = data_byte[7:4];
				left_d          = '0;
				lcnt_d          = '0;
				accum_d         = '0;
				str_d           = '0;
				topics_d        = '0;
				res_d.byte_role = ROLE_HEADER;
				phase_d         = PH_LEN;
			end
			PH_LEN: begin
				res_d.byte_role = ROLE_LENGTH;
				if (lcnt_q >= LEN_MAX_BYTES) begin
					res_d.malformed = 1'b1;
					left_d          = '0;
					lcnt_d          = '0;
					phase_d         = PH_HDR;
				end else begin
					left_d = len_or;
					lcnt_d = lcnt_q + 3'd1;
					if (!data_byte[7]) begin
						if (len_or == 28'd0) begin
							res_d.packet_end = 1'b1;
							phase_d          = PH_HDR;
						end else begin
							phase_d = body_start(kind_q);
						end
					end
				end
			end
			PH_PNL_HI: begin
				res_d.byte_role = ROLE_SKIPPED;
				accum_d         = {data_byte, 8'd0};
				phase_d         = PH_PNL_LO;
			end
			PH_PNL_LO: begin
				res_d.byte_role   = ROLE_SKIPPED;
				res_d.field_value = fv;
				res_d.field_done  = 1'b1;
				if (fv == 16'd0) begin
					str_d   = SKIP4_COUNT;
					phase_d = PH_SKIP4;
				end else begin
					str_d   = fv;
					phase_d = PH_PNAME;
				end
			end
			PH_PNAME: begin
				res_d.byte_role = ROLE_SKIPPED;
				str_d           = str_dec;
				if (str_done) begin
					str_d   = SKIP4_COUNT;
					phase_d = PH_SKIP4;
				end
			end
			PH_SKIP4: begin
				res_d.byte_role = ROLE_SKIPPED;
				str_d           = str_dec;
				if (str_done) begin
					phase_d = PH_IDL_HI;
				end
			end
			PH_IDL_HI: begin
				res_d.byte_role = ROLE_ID_LEN;
				accum_d         = {data_byte, 8'd0};
				phase_d         = PH_IDL_LO;
			end
			PH_IDL_LO: begin
				res_d.byte_role   = ROLE_ID_LEN;
				res_d.field_value = fv;
				res_d.field_done  = 1'b1;
				if (fv == 16'd0) begin
					phase_d = PH_IGNORE;
				end else begin
					str_d   = fv;
					phase_d = PH_CID;
				end
			end
			PH_CID: begin
				res_d.byte_role = ROLE_CLIENT_ID;
				str_d           = str_dec;
				if (str_done) begin
					phase_d = PH_IGNORE;
				end
			end
			PH_IGNORE: begin
				res_d.byte_role = ROLE_IGNORED;
			end
			PH_TL_HI: begin
				res_d.byte_role = ROLE_TOPIC_LEN;
				accum_d         = {data_byte, 8'd0};
				phase_d         = PH_TL_LO;
			end
			PH_TL_LO: begin
				res_d.byte_role   = ROLE_TOPIC_LEN;
				res_d.field_value = fv;
				res_d.field_done  = 1'b1;
				if (kind_q == KIND_SUBSCRIBE && topics_q != TOPIC_MAX) begin
					topics_d = topics_q + 8'd1;
				end
				if (fv == 16'd0) begin
					phase_d = PH_AFTER;
				end else begin
					str_d   = fv;
					phase_d = PH_TOPIC;
				end
			end
			PH_TOPIC: begin
				res_d.byte_role = ROLE_TOPIC;
				str_d           = str_dec;
				if (str_done) begin
					phase_d = PH_AFTER;
				end
			end
			PH_AFTER: begin
				if (kind_q == KIND_SUBSCRIBE) begin
					res_d.byte_role = ROLE_QOS;
					phase_d         = PH_TL_HI;
				end else begin
					res_d.byte_role = ROLE_PAYLOAD;
				end
			end
			PH_PID_HI: begin
				res_d.byte_role = ROLE_PACKET_ID;
				accum_d         = {data_byte, 8'd0};
				phase_d         = PH_PID_LO;
			end
			PH_PID_LO: begin
				res_d.byte_role   = ROLE_PACKET_ID;
				res_d.field_value = fv;
				res_d.field_done  = 1'b1;
				phase_d           = PH_TL_HI;
			end
		endcase

		// count down the body and close the packet when it runs out
		if (phase_q != PH_HDR && phase_q != PH_LEN) begin
			left_d = left_dec;
			if (left_dec == 28'd0) begin
				res_d.packet_end = 1'b1;
				phase_d          = PH_HDR;
			end
		end

		res_d.packet_kind = kind_d;
		res_d.topic_total = topics_d;
		res_d.reply_due   = res_d.packet_end ? reply_for(kind_d) : REPLY_NONE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HDR;
			kind_q   <= '0;
			left_q   <= '0;
			lcnt_q   <= '0;
			accum_q  <= '0;
			str_q    <= '0;
			topics_q <= '0;
		end else if (accept) begin
			phase_q  <= phase_d;
			kind_q   <= kind_d;
			left_q   <= left_d;
			lcnt_q   <= lcnt_d;
			accum_q  <= accum_d;
			str_q    <= str_d;
			topics_q <= topics_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (accept) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= res_d;
		end
	end

	assign result_valid = result_valid_q;
	assign packet_kind  = res_q.packet_kind;
	assign byte_role    = res_q.byte_role;
	assign echo_byte    = res_q.echo_byte;
	assign field_value  = res_q.field_value;
	assign field_done   = res_q.field_done;
	assign packet_end   = res_q.packet_end;
	assign reply_due    = res_q.reply_due;
	assign topic_total  = res_q.topic_total;
	assign malformed    = res_q.malformed;

endmodule

`default_nettype wire

@@ rtl/mpd_checker.sv @@
`default_nettype none
`include "mqtt_packet_deframer_unit_macros.svh"

module mpd_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        byte_valid,
	input wire logic        byte_stall,
	input wire logic [7:0]  data_byte,
	input wire logic        result_valid,
	input wire logic        result_stall,
	input wire logic [3:0]  byte_role,
	input wire logic [7:0]  echo_byte,
	input wire logic [15:0] field_value,
	input wire logic        field_done,
	input wire logic        packet_end,
	input wire logic [1:0]  reply_due,
	input wire logic        malformed
);
	import mpd_pkg::*;

	logic byte_xfer;
	assign byte_xfer = byte_valid && !byte_stall;

	`MPD_ASSERT_NXT(a_result_follows_byte, clk, arst_n, byte_xfer, result_valid && echo_byte == $past(data_byte), "transferred byte not echoed next cycle")
	`MPD_ASSERT_IMP(a_reply_only_at_end, clk, arst_n, result_valid && !packet_end, reply_due == REPLY_NONE, "reply reported off packet end")
	`MPD_ASSERT_IMP(a_malformed_is_length, clk, arst_n, result_valid && malformed, byte_role == ROLE_LENGTH && !packet_end, "malformed flag on a non-length byte")
	`MPD_ASSERT_IMP(a_field_done_role, clk, arst_n, result_valid && field_done, byte_role == ROLE_SKIPPED || byte_role == ROLE_TOPIC_LEN || byte_role == ROLE_PACKET_ID || byte_role == ROLE_ID_LEN, "field completed on a byte with no 16-bit field")
	`MPD_ASSERT_NXT(a_stalled_result_holds, clk, arst_n, result_valid && result_stall, result_valid && $stable(echo_byte) && $stable(byte_role) && $stable(field_value), "stalled result changed")

endmodule

bind mqtt_packet_deframer_unit mpd_checker u_mpd_checker (.*);

`default_nettype wire

@@ sim/tb.sv @@
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import mpd_pkg::*;

	localparam logic [3:0] KIND_AUTH = 4'd15;
	localparam int STUCK_LIMIT = 2000;
	localparam int REPORT_MAX = 10;
	localparam int RANDOM_BYTES = 1100;
	localparam int IDLE_PCT = 19;

	typedef struct packed {
		logic [7:0] b;
		logic       fixed;
		result_t    res;
	} dir_row_t;

	localparam result_t NO_RES = '0;
	localparam int DIR_ROWS = 27;
	localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
		'{8'hC0, 1'b1, '{KIND_PINGREQ, ROLE_HEADER, 8'hC0, 16'd0, 1'b0, 1'b0, REPLY_NONE, 8'd0,
			1'b0}},
		'{8'h00, 1'b1, '{KIND_PINGREQ, ROLE_LENGTH, 8'h00, 16'd0, 1'b0, 1'b1, REPLY_PINGRESP,
			8'd0, 1'b0}},
		'{8'hFF, 1'b1, '{KIND_AUTH, ROLE_HEADER, 8'hFF, 16'd0, 1'b0, 1'b0, REPLY_NONE, 8'd0, 1'b0}},
		'{8'hFF, 1'b1, '{KIND_AUTH, ROLE_LENGTH, 8'hFF, 16'd0, 1'b0, 1'b0, REPLY_NONE, 8'd0, 1'b0}},
		'{8'hFF, 1'b1, '{KIND_AUTH, ROLE_LENGTH, 8'hFF, 16'd0, 1'b0, 1'b0, REPLY_NONE, 8'd0, 1'b0}},
		'{8'hFF, 1'b1, '{KIND_AUTH, ROLE_LENGTH, 8'hFF, 16'd0, 1'b0, 1'b0, REPLY_NONE, 8'd0, 1'b0}},
		'{8'hFF, 1'b1, '{KIND_AUTH, ROLE_LENGTH, 8'hFF, 16'd0, 1'b0, 1'b0, REPLY_NONE, 8'd0, 1'b0}},
		'{8'hFF, 1'b1, '{KIND_AUTH, ROLE_LENGTH, 8'hFF, 16'd0, 1'b0, 1'b0, REPLY_NONE, 8'd0, 1'b1}},
		'{8'h10, 1'b0, NO_RES},
		'{8'h03, 1'b0, NO_RES},
		'{8'h00, 1'b0, NO_RES},
		'{8'h00, 1'b0, NO_RES},
		'{8'h07, 1'b0, NO_RES},
		'{8'h3F, 1'b0, NO_RES},
		'{8'h04, 1'b0, NO_RES},
		'{8'h00, 1'b0, NO_RES},
		'{8'h01, 1'b0, NO_RES},
		'{8'h54, 1'b0, NO_RES},
		'{8'hFF, 1'b0, NO_RES},
		'{8'h82, 1'b0, NO_RES},
		'{8'h03, 1'b0, NO_RES},
		'{8'hFF, 1'b0, NO_RES},
		'{8'hFF, 1'b0, NO_RES},
		'{8'h00, 1'b0, NO_RES},
		'{8'h5F, 1'b0, NO_RES},
		'{8'h01, 1'b0, NO_RES},
		'{8'h80, 1'b0, NO_RES}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        byte_valid = 1'b0;
	logic        byte_stall;
	logic [7:0]  data_byte = 8'h00;
	logic        result_valid;
	logic        result_stall = 1'b0;
	logic [3:0]  packet_kind;
	logic [3:0]  byte_role;
	logic [7:0]  echo_byte;
	logic [15:0] field_value;
	logic        field_done;
	logic        packet_end;
	logic [1:0]  reply_due;
	logic [7:0]  topic_total;
	logic        malformed;

	mqtt_packet_deframer_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (byte_valid),
		.byte_stall   (byte_stall),
		.data_byte    (data_byte),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.packet_kind  (packet_kind),
		.byte_role    (byte_role),
		.echo_byte    (echo_byte),
		.field_value  (field_value),
		.field_done   (field_done),
		.packet_end   (packet_end),
		.reply_due    (reply_due),
		.topic_total  (topic_total),
		.malformed    (malformed)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// parser state mirror
	phase_t      ph = PH_HDR;
	logic [3:0]  kind_q = '0;
	logic [27:0] left_q = '0;
	logic [2:0]  lcount = '0;
	logic [15:0] accum = '0;
	logic [15:0] str_left = '0;
	logic [7:0]  topics = '0;

	result_t  tag_queue [$];
	dir_row_t cur_row = '0;
	bit       quiet = 1'b0;
	int       mismatches = 0;
	int       n_transfers = 0;
	int       n_ends = 0;
	int       n_connack = 0;
	int       n_suback = 0;
	int       n_pingresp = 0;
	int       n_malformed = 0;
	int       n_saturated = 0;
	int       stuck_cycles = 0;

	logic [7:0] body_q [$];
	logic [7:0] pkt_bytes [$];

	function automatic void put_tag(input result_t r);
		tag_queue.insert(tag_queue.size(), r);
	endfunction

	function automatic void put_body(input logic [7:0] b);
		body_q.insert(body_q.size(), b);
	endfunction

	function automatic void put_pkt(input logic [7:0] b);
		pkt_bytes.insert(pkt_bytes.size(), b);
	endfunction

	function bit string_done();
		if (str_left != 0)
			str_left = str_left - 1'b1;
		return str_left == 0;
	endfunction

	task automatic tag_byte(input logic [7:0] b, output result_t r);
		logic [15:0] fv;
		r = '0;
		r.byte_role = ROLE_IGNORED;
		r.echo_byte = b;
		if (ph == PH_HDR) begin
			kind_q = b[7:4];
			left_q = '0;
			lcount = '0;
			accum = '0;
			str_left = '0;
			topics = '0;
			r.byte_role = ROLE_HEADER;
			ph = PH_LEN;
		end else if (ph == PH_LEN) begin
			r.byte_role = ROLE_LENGTH;
			if (lcount >= LEN_MAX_BYTES) begin
				r.malformed = 1'b1;
				left_q = '0;
				lcount = '0;
				ph = PH_HDR;
			end else begin
				left_q = left_q | (28'(b[6:0]) << (7 * lcount));
				lcount = lcount + 1'b1;
				if (!b[7]) begin
					if (left_q == 0) begin
						r.packet_end = 1'b1;
						ph = PH_HDR;
					end else begin
						case (kind_q)
							KIND_CONNECT:   ph = PH_PNL_HI;
							KIND_PUBLISH:   ph = PH_TL_HI;
							KIND_SUBSCRIBE: ph = PH_PID_HI;
							default:        ph = PH_IGNORE;
						endcase
					end
				end
			end
		end else begin
			fv = {accum[15:8], b};
			case (ph)
				PH_PNL_HI: begin
					r.byte_role = ROLE_SKIPPED;
					accum = {b, 8'h00};
					ph = PH_PNL_LO;
				end
				PH_PNL_LO: begin
					r.byte_role = ROLE_SKIPPED;
					r.field_value = fv;
					r.field_done = 1'b1;
					if (fv == 0) begin
						str_left = SKIP4_COUNT;
						ph = PH_SKIP4;
					end else begin
						str_left = fv;
						ph = PH_PNAME;
					end
				end
				PH_PNAME: begin
					r.byte_role = ROLE_SKIPPED;
					if (string_done()) begin
						str_left = SKIP4_COUNT;
						ph = PH_SKIP4;
					end
				end
				PH_SKIP4: begin
					r.byte_role = ROLE_SKIPPED;
					if (string_done())
						ph = PH_IDL_HI;
				end
				PH_IDL_HI: begin
					r.byte_role = ROLE_ID_LEN;
					accum = {b, 8'h00};
					ph = PH_IDL_LO;
				end
				PH_IDL_LO: begin
					r.byte_role = ROLE_ID_LEN;
					r.field_value = fv;
					r.field_done = 1'b1;
					if (fv == 0) begin
						ph = PH_IGNORE;
					end else begin
						str_left = fv;
						ph = PH_CID;
					end
				end
				PH_CID: begin
					r.byte_role = ROLE_CLIENT_ID;
					if (string_done())
						ph = PH_IGNORE;
				end
				PH_TL_HI: begin
					r.byte_role = ROLE_TOPIC_LEN;
					accum = {b, 8'h00};
					ph = PH_TL_LO;
				end
				PH_TL_LO: begin
					r.byte_role = ROLE_TOPIC_LEN;
					r.field_value = fv;
					r.field_done = 1'b1;
					if (kind_q == KIND_SUBSCRIBE && topics < TOPIC_MAX)
						topics = topics + 1'b1;
					if (fv == 0) begin
						ph = PH_AFTER;
					end else begin
						str_left = fv;
						ph = PH_TOPIC;
					end
				end
				PH_TOPIC: begin
					r.byte_role = ROLE_TOPIC;
					if (string_done())
						ph = PH_AFTER;
				end
				PH_AFTER: begin
					if (kind_q == KIND_SUBSCRIBE) begin
						r.byte_role = ROLE_QOS;
						ph = PH_TL_HI;
					end else begin
						r.byte_role = ROLE_PAYLOAD;
					end
				end
				PH_PID_HI: begin
					r.byte_role = ROLE_PACKET_ID;
					accum = {b, 8'h00};
					ph = PH_PID_LO;
				end
				PH_PID_LO: begin
					r.byte_role = ROLE_PACKET_ID;
					r.field_value = fv;
					r.field_done = 1'b1;
					ph = PH_TL_HI;
				end
				default: begin
					r.byte_role = ROLE_IGNORED;
				end
			endcase
			if (left_q != 0)
				left_q = left_q - 1'b1;
			if (left_q == 0) begin
				r.packet_end = 1'b1;
				ph = PH_HDR;
			end
		end
		r.packet_kind = kind_q;
		r.topic_total = topics;
		if (r.packet_end) begin
			case (kind_q)
				KIND_CONNECT:   r.reply_due = REPLY_CONNACK;
				KIND_SUBSCRIBE: r.reply_due = REPLY_SUBACK;
				KIND_PINGREQ:   r.reply_due = REPLY_PINGRESP;
				default:        r.reply_due = REPLY_NONE;
			endcase
		end
	endtask

	function automatic string fmt_tag(result_t r);
		return $sformatf({"kind=%0d role=%0d byte=%02h value=%04h done=%0b end=%0b",
			" reply=%0d topics=%0d mal=%0b"},
			r.packet_kind, r.byte_role, r.echo_byte, r.field_value, r.field_done,
			r.packet_end, r.reply_due, r.topic_total, r.malformed);
	endfunction

	always @(posedge clk) begin : check_tags
		result_t got;
		result_t want;
		result_t pred;
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				got = {packet_kind, byte_role, echo_byte, field_value, field_done,
					packet_end, reply_due, topic_total, malformed};
				n_transfers++;
				if (got.packet_end) n_ends++;
				if (got.packet_end && got.reply_due == REPLY_CONNACK) n_connack++;
				if (got.packet_end && got.reply_due == REPLY_SUBACK) n_suback++;
				if (got.packet_end && got.reply_due == REPLY_PINGRESP) n_pingresp++;
				if (got.malformed) n_malformed++;
				if (got.topic_total == TOPIC_MAX) n_saturated++;
				if (tag_queue.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_MAX)
						$display("unexpected result at %0t: %s", $realtime, fmt_tag(got));
				end else begin
					want = tag_queue.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= REPORT_MAX)
							$display("mismatch at %0t\n  expected %s\n  actual   %s",
								$realtime, fmt_tag(want), fmt_tag(got));
					end
				end
			end
			if (byte_valid && !byte_stall) begin
				tag_byte(data_byte, pred);
				put_tag(cur_row.fixed ? cur_row.res : pred);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (byte_valid && !byte_stall) || (result_valid && !result_stall))
			stuck_cycles <= 0;
		else
			stuck_cycles <= stuck_cycles + 1;
		if (stuck_cycles >= STUCK_LIMIT) begin
			$display("** mqtt_packet_deframer_unit: FAILED **");
			$finish;
		end
	end

	always @(negedge clk) begin
		result_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
	end

	task automatic send_byte(input dir_row_t row);
		while (!quiet && $urandom_range(99) < IDLE_PCT) begin
			byte_valid <= 1'b0;
			@(negedge clk);
		end
		byte_valid <= 1'b1;
		data_byte <= row.b;
		cur_row <= row;
		@(posedge clk);
		while (byte_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	// hold until the pipeline is empty
	task automatic drain_results();
		byte_valid <= 1'b0;
		do
			@(negedge clk);
		while (tag_queue.size() != 0);
	endtask

	function automatic logic [15:0] pick_len();
		int s;
		s = $urandom_range(99);
		if (s < 85)
			return 16'($urandom_range(6));
		if (s < 92)
			return 16'hFFFF;
		return 16'($urandom);
	endfunction

	task automatic add_string(input logic [15:0] n);
		int m;
		put_body(n[15:8]);
		put_body(n[7:0]);
		m = (n > 8) ? 8 : int'(n);
		repeat (m) put_body(8'($urandom));
	endtask

	task automatic frame_packet(input logic [7:0] hdr, input bit allow_cut);
		int rl;
		int rest;
		int n_len;
		logic [7:0] lb;
		pkt_bytes.delete();
		put_pkt(hdr);
		rl = body_q.size();
		if (allow_cut && rl > 0 && $urandom_range(99) < 15)
			rl = $urandom_range(rl - 1);
		rest = rl;
		n_len = 0;
		do begin
			lb = 8'(rest % 128);
			rest = rest / 128;
			if (rest > 0)
				lb[7] = 1'b1;
			put_pkt(lb);
			n_len++;
		end while (rest > 0);
		// pad with an overlong but legal length encoding
		if (n_len < LEN_MAX_BYTES && $urandom_range(99) < 10) begin
			lb = pkt_bytes.pop_back();
			put_pkt(lb | 8'h80);
			put_pkt(8'h00);
		end
		for (int i = 0; i < rl; i++)
			put_pkt(body_q[i]);
	endtask

	task automatic build_packet();
		int sel;
		int n;
		sel = $urandom_range(99);
		body_q.delete();
		if (sel < 25) begin
			add_string(pick_len());
			repeat (4) put_body(8'($urandom));
			add_string(pick_len());
			repeat ($urandom_range(2)) put_body(8'($urandom));
			frame_packet({KIND_CONNECT, 4'($urandom)}, 1'b1);
		end else if (sel < 50) begin
			add_string(pick_len());
			n = ($urandom_range(99) < 5) ? $urandom_range(120, 200) : $urandom_range(8);
			repeat (n) put_body(8'($urandom));
			frame_packet({KIND_PUBLISH, 4'($urandom)}, 1'b1);
		end else if (sel < 75) begin
			put_body(8'($urandom));
			put_body(8'($urandom));
			repeat ($urandom_range(1, 4)) begin
				add_string(pick_len());
				put_body(8'($urandom));
			end
			frame_packet({KIND_SUBSCRIBE, 4'($urandom)}, 1'b1);
		end else if (sel < 85) begin
			if ($urandom_range(99) < 20)
				repeat ($urandom_range(1, 3)) put_body(8'($urandom));
			frame_packet({KIND_PINGREQ, 4'($urandom)}, 1'b1);
		end else if (sel < 95) begin
			repeat ($urandom_range(5)) put_body(8'($urandom));
			frame_packet(8'($urandom), 1'b1);
		end else begin
			// length field that never terminates
			pkt_bytes.delete();
			put_pkt(8'($urandom));
			repeat (LEN_MAX_BYTES) put_pkt(8'($urandom) | 8'h80);
			put_pkt(8'($urandom));
		end
	endtask

	// enough empty topics to saturate the topic count
	task automatic build_wide_subscribe();
		body_q.delete();
		put_body(8'($urandom));
		put_body(8'($urandom));
		repeat (int'(TOPIC_MAX) + 5) begin
			put_body(8'h00);
			put_body(8'h00);
			put_body(8'($urandom_range(2)));
		end
		frame_packet({KIND_SUBSCRIBE, 4'h2}, 1'b0);
	endtask

	initial begin : stimulus
		dir_row_t row;
		int sent_random;
		int pkt_idx;
		int wait_cycles;
		bit wide;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int i = 0; i < DIR_ROWS; i++)
			send_byte(DIR_TABLE[i]);
		drain_results();

		sent_random = 0;
		pkt_idx = 0;
		while (sent_random < RANDOM_BYTES) begin
			wide = (pkt_idx == 5);
			if (wide)
				build_wide_subscribe();
			else
				build_packet();
			foreach (pkt_bytes[i]) begin
				quiet = (sent_random >= 400 && sent_random < 600);
				row = '0;
				row.b = pkt_bytes[i];
				send_byte(row);
				sent_random++;
			end
			if (pkt_idx == 12)
				drain_results();
			pkt_idx++;
		end
		quiet = 1'b0;

		byte_valid <= 1'b0;
		wait_cycles = 0;
		while (tag_queue.size() != 0 && wait_cycles < STUCK_LIMIT) begin
			@(negedge clk);
			wait_cycles++;
		end
		repeat (4) @(negedge clk);
		if (tag_queue.size() != 0) begin
			$display("%0d results never arrived", tag_queue.size());
			mismatches += tag_queue.size();
		end

		$display("run: %0d bytes checked over %0d packet ends, %0d malformed length fields",
			n_transfers, n_ends, n_malformed);
		$display("replies: %0d connack, %0d suback, %0d pingresp; %0d bytes at topic count limit",
			n_connack, n_suback, n_pingresp, n_saturated);
		if (mismatches == 0) begin
			$display("** mqtt_packet_deframer_unit: PASSED **");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("** mqtt_packet_deframer_unit: FAILED **");
		end
		$finish;
	end

endmodule

`default_nettype wire
